/* hdl/siu_pkg.sv */
// Shared constants, command/status types and the sinc coefficient table
// for the sinc interpolating upsampler. No dependencies.
`default_nettype none

package siu_pkg;

    localparam int UPSAMPLE     = 8;
    localparam int HALF_WINDOW  = 8;
    localparam int SAMPLE_BITS  = 16;
    localparam int WIN          = 2 * HALF_WINDOW;
    localparam int ROM_DEPTH    = UPSAMPLE * WIN;
    localparam int COEF_BITS    = 16;
    localparam int COEF_FRAC    = 14;
    localparam int PH_BITS      = $clog2(UPSAMPLE);
    localparam int ROM_IDX_BITS = $clog2(ROM_DEPTH);
    localparam int PROD_BITS    = SAMPLE_BITS + COEF_BITS;
    localparam int GROUP_SIZE   = 4;
    localparam int GROUPS       = WIN / GROUP_SIZE;
    localparam int PART_BITS    = PROD_BITS + $clog2(GROUP_SIZE);
    localparam int ACC_BITS     = PROD_BITS + $clog2(WIN);

    localparam logic [ROM_IDX_BITS-1:0] ROM_CENTER = ROM_IDX_BITS'(UPSAMPLE * HALF_WINDOW);
    localparam logic [PH_BITS-1:0]      LAST_PHASE = PH_BITS'(UPSAMPLE - 1);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic               load;   // capture the new sample
        logic               issue;  // start one output phase in the pipeline
        logic [PH_BITS-1:0] phase;  // phase being issued
        logic               last;   // phase is the final one of the run
        logic               shift;  // move the held sample into the window
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic adv;                  // pipeline moves forward this cycle
    } t_dp_status;

    // Normalized sinc((j - M*W/2) / M) in Q2.14, for the table entry j.
    function automatic logic signed [COEF_BITS-1:0] coef_at(
        input logic [ROM_IDX_BITS-1:0] idx
    );
        logic [ROM_IDX_BITS-1:0]    a;
        logic signed [COEF_BITS-1:0] v;
        a = (idx >= ROM_CENTER) ? (idx - ROM_CENTER) : (ROM_CENTER - idx);
        case (a)
            7'd0:  v = 16'sd16384;
            7'd1:  v = 16'sd15966;
            7'd2:  v = 16'sd14751;
            7'd3:  v = 16'sd12849;
            7'd4:  v = 16'sd10430;
            7'd5:  v = 16'sd7709;
            7'd6:  v = 16'sd4917;
            7'd7:  v = 16'sd2281;
            7'd9:  v = -16'sd1774;
            7'd10: v = -16'sd2950;
            7'd11: v = -16'sd3504;
            7'd12: v = -16'sd3477;
            7'd13: v = -16'sd2965;
            7'd14: v = -16'sd2107;
            7'd15: v = -16'sd1064;
            7'd17: v = 16'sd939;
            7'd18: v = 16'sd1639;
            7'd19: v = 16'sd2029;
            7'd20: v = 16'sd2086;
            7'd21: v = 16'sd1836;
            7'd22: v = 16'sd1341;
            7'd23: v = 16'sd694;
            7'd25: v = -16'sd639;
            7'd26: v = -16'sd1135;
            7'd27: v = -16'sd1428;
            7'd28: v = -16'sd1490;
            7'd29: v = -16'sd1329;
            7'd30: v = -16'sd983;
            7'd31: v = -16'sd515;
            7'd33: v = 16'sd484;
            7'd34: v = 16'sd868;
            7'd35: v = 16'sd1101;
            7'd36: v = 16'sd1159;
            7'd37: v = 16'sd1042;
            7'd38: v = 16'sd776;
            7'd39: v = 16'sd409;
            7'd41: v = -16'sd389;
            7'd42: v = -16'sd702;
            7'd43: v = -16'sd896;
            7'd44: v = -16'sd948;
            7'd45: v = -16'sd857;
            7'd46: v = -16'sd641;
            7'd47: v = -16'sd340;
            7'd49: v = 16'sd326;
            7'd50: v = 16'sd590;
            7'd51: v = 16'sd756;
            7'd52: v = 16'sd802;
            7'd53: v = 16'sd727;
            7'd54: v = 16'sd546;
            7'd55: v = 16'sd290;
            7'd57: v = -16'sd280;
            7'd58: v = -16'sd509;
            7'd59: v = -16'sd653;
            7'd60: v = -16'sd695;
            7'd61: v = -16'sd632;
            7'd62: v = -16'sd476;
            7'd63: v = -16'sd253;
            // Nonzero multiples of the upsampling factor are sinc zeros.
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hdl/siu_ctrl.sv */
// Controller of the sinc upsampler: accepts input transfers and steps
// through the output phases. Depends on siu_pkg.
`default_nettype none

module siu_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  siu_pkg::t_dp_status i_status,
    output siu_pkg::t_dp_cmd    o_cmd
);
    import siu_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state             r_state, n_state;
    logic [PH_BITS-1:0] r_phase, n_phase;
    logic               w_last;
    logic               w_accept;

    assign w_last = (r_phase == LAST_PHASE);

    // A new sample may enter as the final phase of the previous one issues.
    assign o_in_stall = !((r_state == S_IDLE) ||
                          ((r_state == S_RUN) && w_last && i_status.adv));
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd.load  = w_accept;
        o_cmd.issue = (r_state == S_RUN) && i_status.adv;
        o_cmd.phase = r_phase;
        o_cmd.last  = w_last;
        o_cmd.shift = (r_state == S_RUN) && i_status.adv && w_last;
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RUN;
                    n_phase = '0;
                end
            end
            S_RUN: begin
                if (i_status.adv) begin
                    if (w_last) begin
                        n_phase = '0;
                        n_state = w_accept ? S_RUN : S_IDLE;
                    end else begin
                        n_phase = r_phase + PH_BITS'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
                n_phase = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

`default_nettype wire

/* hdl/siu_datapath.sv */
// Datapath of the sinc upsampler: sample window, multiply array, adder
// tree, rounding, saturation and output register. Depends on siu_pkg.
`default_nettype none

module siu_datapath (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  siu_pkg::t_dp_cmd                 i_cmd,
    input  wire  [siu_pkg::SAMPLE_BITS-1:0]  i_sample,
    output siu_pkg::t_dp_status              o_status,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [siu_pkg::SAMPLE_BITS-1:0]  o_out_sample,
    output logic                             o_last_of_run
);
    import siu_pkg::*;

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1) <<< (COEF_FRAC - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_MAX =
        ACC_BITS'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_MIN = -SAT_MAX - ACC_BITS'(1);

    logic signed [SAMPLE_BITS-1:0] r_win [WIN];
    logic signed [SAMPLE_BITS-1:0] r_hold;
    logic signed [COEF_BITS-1:0]   w_coef [WIN];

    logic signed [PROD_BITS-1:0]   r_prod [WIN];
    logic                          r_v1, r_last1;
    logic signed [PART_BITS-1:0]   r_part [GROUPS];
    logic signed [PART_BITS-1:0]   w_part [GROUPS];
    logic                          r_v2, r_last2;

    logic signed [ACC_BITS-1:0]    w_acc, w_t, w_q;
    logic [SAMPLE_BITS-1:0]        w_sat;
    logic                          w_adv;

    // The whole pipeline holds while a finished result waits downstream.
    assign w_adv        = !o_out_valid || !i_out_stall;
    assign o_status.adv = w_adv;

    // Tap k of phase p uses table entry (M-1-p) + k*M.
    always_comb begin
        for (int k = 0; k < WIN; k++) begin
            w_coef[k] = coef_at(ROM_IDX_BITS'(k * UPSAMPLE + UPSAMPLE - 1)
                                - ROM_IDX_BITS'(i_cmd.phase));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hold <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_cmd.shift) begin
            for (int k = 0; k < WIN - 1; k++) begin
                r_win[k] <= r_win[k + 1];
            end
            r_win[WIN-1] <= r_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < WIN; k++) begin
                r_prod[k] <= PROD_BITS'(r_win[k]) * PROD_BITS'(w_coef[k]);
            end
            r_last1 <= i_cmd.last;
        end
    end

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            w_part[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                w_part[g] = w_part[g] + PART_BITS'(r_prod[g * GROUP_SIZE + j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int g = 0; g < GROUPS; g++) begin
                r_part[g] <= w_part[g];
            end
            r_last2 <= r_last1;
        end
    end

    // Round half up by adding half an LSB before the arithmetic shift.
    always_comb begin
        w_acc = '0;
        for (int g = 0; g < GROUPS; g++) begin
            w_acc = w_acc + ACC_BITS'(r_part[g]);
        end
        w_t = w_acc + ROUND_HALF;
        w_q = w_t >>> COEF_FRAC;
        if (w_q > SAT_MAX) begin
            w_sat = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (w_q < SAT_MIN) begin
            w_sat = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            w_sat = w_q[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_out_sample  <= w_sat;
            o_last_of_run <= r_last2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_v1        <= i_cmd.issue;
            r_v2        <= r_v1;
            o_out_valid <= r_v2;
        end
    end

endmodule

`default_nettype wire

/* hdl/sinc_interpolating_upsampler.sv */
// Top level of the sinc interpolating upsampler: joins the controller and
// the datapath. Depends on siu_pkg, siu_ctrl and siu_datapath.
`default_nettype none

// Windowed-sinc upsampler by 8 over a 16-sample window. Each input transfer
// produces 8 output transfers, one per interpolation phase, the last flagged
// by o_last_of_run; the results use the window held before that sample,
// which then enters the window. The 16-lane multiply array computes one
// phase per cycle while the output is not stalled; the next input can be
// taken as the final phase of the current one issues. Each result passes
// the product, partial-sum and output registers, and output stall freezes
// the whole three-stage pipeline. The window is zero after reset.
module sinc_interpolating_upsampler (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  wire  [siu_pkg::SAMPLE_BITS-1:0]  i_in_sample,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output logic [siu_pkg::SAMPLE_BITS-1:0]  o_out_sample,
    output logic                             o_last_of_run
);
    import siu_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    siu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    siu_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_sample      (i_in_sample),
        .o_status      (w_status),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_sample  (o_out_sample),
        .o_last_of_run (o_last_of_run)
    );

`ifndef SYNTHESIS
    // A new sample is only taken when no phase is issuing or the final
    // phase of the previous run is.
    a_accept_at_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> (!w_cmd.issue || w_cmd.shift))
        else $error("input transfer in the middle of a run");

    // A run starts at the first phase only right after a sample was loaded,
    // or after a stalled cycle.
    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.issue && (w_cmd.phase == '0)) |-> ($past(w_cmd.load) || $past(!w_cmd.issue)))
        else $error("phase counter restarted without a new sample");

    // The pipeline never moves while a result waits under stall.
    a_hold_under_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !w_cmd.issue)
        else $error("phase issued while output is stalled");
`endif

endmodule

`default_nettype wire

/* verif/sinc_interpolating_upsampler_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the sinc interpolating upsampler. It predicts
// every output transfer from its own integer sinc table and sample window.
// Depends on siu_pkg and sinc_interpolating_upsampler.

module sinc_interpolating_upsampler_tb;

    import siu_pkg::*;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int ONE_Q14       = 16384;
    localparam int RESET_CYCLES  = 9;
    localparam int ITEMS_PER_MIX = 78;
    localparam int TAIL_CYCLES   = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PRINT_LIMIT   = 40;
    localparam int N_DIRECTED    = 22;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef struct {
        t_sample sample;
        logic    last;
    } t_interp_out;

    // Holds the sample window and the sinc taps, and the queue of outputs
    // that the accepted inputs still owe.
    class interp_scoreboard;
        logic signed [SAMPLE_BITS-1:0] window [WIN];
        int          taps [ROM_DEPTH];
        t_interp_out owed [$];
        int          mismatches = 0;
        int          inputs_taken = 0;
        int          outputs_checked = 0;
        int          saturated = 0;

        function new();
            foreach (window[k]) window[k] = '0;
            foreach (taps[j]) taps[j] = sinc_q14(j);
        endfunction

        // sin(pi*r/M) by a truncated Taylor series in Q30, scaled into a
        // normalized sinc tap in Q2.14.
        static function int sinc_q14(int j);
            longint          d;
            longint unsigned a, r, s, ang, term, den, q, n;
            longint          sum;
            bit              neg;
            d = j - UPSAMPLE * HALF_WINDOW;
            a = (d < 0) ? -d : d;
            if (a == 0)
                return ONE_Q14;
            r = a % (2 * UPSAMPLE);
            neg = (r >= UPSAMPLE);
            if (neg)
                r = r - UPSAMPLE;
            if (r == 0)
                return 0;
            if (2 * r > UPSAMPLE)
                r = UPSAMPLE - r;
            ang = PI_Q30 * r / UPSAMPLE;
            term = ang;
            sum = ang;
            for (n = 1; n <= 6; n++) begin
                term = ((((term * ang) >> 30) * ang) >> 30) / ((2 * n) * (2 * n + 1));
                if (n[0])
                    sum = sum - longint'(term);
                else
                    sum = sum + longint'(term);
            end
            s = (sum < 0) ? 0 : sum;
            den = PI_Q30 * a;
            q = (s * UPSAMPLE * 64'd16384 + den / 2) / den;
            return neg ? -int'(q) : int'(q);
        endfunction

        function t_sample interpolate_phase(int p);
            longint acc;
            longint rounded;
            longint hi;
            longint lo;
            acc = 0;
            hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
            lo = -hi - 1;
            for (int k = 0; k < WIN; k++)
                acc += longint'(window[k]) * taps[(UPSAMPLE - 1 - p) + k * UPSAMPLE];
            // Round half up, then floor: the arithmetic shift gives the floor.
            rounded = (acc + 8192) >>> 14;
            if (rounded > hi) begin
                rounded = hi;
                saturated++;
            end else if (rounded < lo) begin
                rounded = lo;
                saturated++;
            end
            return rounded[SAMPLE_BITS-1:0];
        endfunction

        function void take_sample(t_sample s);
            t_interp_out item;
            for (int p = 0; p < UPSAMPLE; p++) begin
                item.sample = interpolate_phase(p);
                item.last = (p == UPSAMPLE - 1);
                owed = {owed, item};
            end
            for (int k = 0; k + 1 < WIN; k++)
                window[k] = window[k + 1];
            window[WIN - 1] = s;
            inputs_taken++;
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_output(t_sample got_sample, logic got_last);
            t_interp_out want;
            if (owed.size() == 0) begin
                report($sformatf("output %h with nothing owed", got_sample));
                return;
            end
            want = owed.pop_front();
            outputs_checked++;
            if (got_sample !== want.sample)
                report($sformatf("output %0d: sample %h, wanted %h",
                                 outputs_checked, got_sample, want.sample));
            if (got_last !== want.last)
                report($sformatf("output %0d: last_of_run %b, wanted %b",
                                 outputs_checked, got_last, want.last));
        endtask
    endclass

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    in_valid = 1'b0;
    t_sample in_sample = '0;
    logic    out_stall = 1'b0;
    wire     o_in_stall;
    wire     o_out_valid;
    wire     [SAMPLE_BITS-1:0] o_out_sample;
    wire     o_last_of_run;

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int cycle_count = 0;
    interp_scoreboard sb;

    sinc_interpolating_upsampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_sample   (in_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_out_sample  (o_out_sample),
        .o_last_of_run (o_last_of_run)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !o_in_stall)
            sb.take_sample(in_sample);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall)
            sb.check_output(o_out_sample, o_last_of_run);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d outputs owed",
                     cycle_count, sb.owed.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Valid stays high from one transfer to the next unless the sender
    // decides to idle first, so it is never lowered and raised in one step.
    task automatic send_sample(input t_sample s);
        if ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        in_valid <= 1'b1;
        in_sample <= s;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.owed.size() != 0);
    endtask

    function automatic t_sample random_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return t_sample'($urandom_range(255)) - 16'd128;
            3:       return $urandom_range(1) ? 16'h7FFF - t_sample'($urandom_range(63))
                                              : 16'h8000 + t_sample'($urandom_range(63));
            default: return t_sample'($urandom);
        endcase
    endfunction

    t_sample directed [N_DIRECTED] = '{
        16'h0000, 16'h0001, 16'hFFFF,
        16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
        16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
        16'h5555, 16'hAAAA, 16'h0000
    };

    int idle_mix  [4] = '{0, 58, 0, 31};
    int stall_mix [4] = '{0, 0, 58, 31};

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero window first, then extremes of alternating sign that drive
        // most phases into saturation in both directions.
        foreach (directed[i])
            send_sample(directed[i]);
        wait_drained();

        // Each mix ends with the sender waiting until all outputs are back.
        for (int m = 0; m < 4; m++) begin
            in_idle_pct = idle_mix[m];
            out_stall_pct = stall_mix[m];
            repeat (ITEMS_PER_MIX)
                send_sample(random_sample());
            wait_drained();
        end

        out_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.owed.size() != 0)
            sb.report($sformatf("%0d outputs never arrived", sb.owed.size()));

        $display("Covered %0d input and %0d output transfers (%0d saturated) over four",
                 sb.inputs_taken, sb.outputs_checked, sb.saturated);
        $display("idle/stall mixes; %0d mismatches.", sb.mismatches);
        if (sb.mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
hdl/siu_pkg.sv
hdl/siu_ctrl.sv
hdl/siu_datapath.sv
hdl/sinc_interpolating_upsampler.sv
verif/sinc_interpolating_upsampler_tb.sv
